// ===== src/bba_pkg.sv =====
// Shared types and constants of the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

   localparam int WordBits = 64;
   localparam int BitIdxW  = 6;
   localparam int BlockW   = 12;
   localparam int CountW   = 13;
   localparam int StatusW  = 2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [StatusW-1:0] STATUS_OK           = 2'd0;
   localparam logic [StatusW-1:0] STATUS_FULL         = 2'd1;
   localparam logic [StatusW-1:0] STATUS_ALREADY_FREE = 2'd2;
   localparam logic [StatusW-1:0] STATUS_RANGE        = 2'd3;

   typedef logic [WordBits-1:0] map_word_type;

   typedef struct packed {
      logic               found;
      logic [BitIdxW-1:0] bit_idx;
   } scan_result_type;

endpackage
`default_nettype wire

// ===== src/bba_map_ram.sv =====
// Usage bitmap memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module bba_map_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire                   clock,
   input  wire                   wr_en,
   input  wire [AW-1:0]          wr_addr,
   input  bba_pkg::map_word_type wr_data,
   input  wire                   rd_en,
   input  wire [AW-1:0]          rd_addr,
   output bba_pkg::map_word_type rd_data
);

   bba_pkg::map_word_type mem [0:DEPTH-1];
   bba_pkg::map_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/bba_word_scan.sv =====
// Lowest free bit search over one bitmap word, with tail masking.
`timescale 1ns / 1ps
`default_nettype none
module bba_word_scan (
   input  bba_pkg::map_word_type            used_word,
   input  wire                              tail_valid,
   input  wire [bba_pkg::BitIdxW-1:0]       tail_len,
   output bba_pkg::scan_result_type         result
);

   bba_pkg::map_word_type   free_bits;
   bba_pkg::map_word_type   v;
   bba_pkg::map_word_type   low_mask;
   logic [bba_pkg::BitIdxW-1:0] idx;

   always_comb begin
      for (int i = 0; i < bba_pkg::WordBits; i++) begin
         free_bits[i] = !used_word[i] &&
                        (!tail_valid || (bba_pkg::BitIdxW'(i) < tail_len));
      end
   end

   always_comb begin
      v   = free_bits;
      idx = '0;
      for (int lvl = bba_pkg::BitIdxW - 1; lvl >= 0; lvl--) begin
         low_mask = (bba_pkg::map_word_type'(1) << (1 << lvl)) - 1'b1;
         if ((v & low_mask) == '0) begin
            idx[lvl] = 1'b1;
            v        = v >> (1 << lvl);
         end
      end
      result.found   = |free_bits;
      result.bit_idx = idx;
   end

endmodule
`default_nettype wire

// ===== src/bitmap_block_allocator.sv =====
// Top level of the bitmap block allocator: request sequencer and count.
`timescale 1ns / 1ps
`default_nettype none
// After reset the block clears its bitmap one 64-bit word per cycle, with busy high; csr
// writes are taken throughout. A free request makes one bitmap read, then the write-back
// when the block was in use; a block out of range is answered without a read. An allocate
// request reads words up to and including the one that holds the first free block, or up
// to the last word below the limit: the scan reads one word per cycle from the single read
// port; with a zero limit it answers full without a read. Each result shows for one cycle
// with rsp_strobe; it cannot be held off, and busy is already low in that cycle, so the
// next item may start then.
module bitmap_block_allocator #(
   parameter int MAX_BLOCKS = 4096
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire                                req_command,
   input  wire [bba_pkg::BlockW-1:0]          req_block_number,
   output logic                               rsp_strobe,
   output logic [bba_pkg::BlockW-1:0]         rsp_block_number_res,
   output logic [bba_pkg::StatusW-1:0]        rsp_status,
   output logic [bba_pkg::CountW-1:0]         rsp_used_count,
   input  wire                                csr_write_en,
   input  wire [bba_pkg::CountW-1:0]          csr_write_data
);

   localparam int MapWords = (MAX_BLOCKS + bba_pkg::WordBits - 1) / bba_pkg::WordBits;
   localparam int WIdxW    = (MapWords > 1) ? $clog2(MapWords) : 1;
   localparam int LimW     = ($clog2(MAX_BLOCKS + 1) > bba_pkg::CountW) ?
                             $clog2(MAX_BLOCKS + 1) : bba_pkg::CountW;
   localparam int CmpW     = ((LimW > WIdxW + bba_pkg::BitIdxW) ?
                             LimW : (WIdxW + bba_pkg::BitIdxW)) + 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FREE
   } state_type;

   state_type                     state_ff, state_in;
   logic [bba_pkg::CountW-1:0]    total_ff;
   logic [bba_pkg::CountW-1:0]    count_ff, count_in;
   logic [WIdxW-1:0]              ptr_ff, ptr_in;
   logic [bba_pkg::BlockW-1:0]    blk_ff, blk_in;
   logic                          strobe_ff, strobe_in;
   logic [bba_pkg::BlockW-1:0]    res_ff, res_in;
   logic [bba_pkg::StatusW-1:0]   status_ff, status_in;

   logic [LimW-1:0]               total_ext;
   logic [LimW-1:0]               limit;
   logic [CmpW-1:0]               base;
   logic [CmpW-1:0]               remain;
   logic [CmpW-1:0]               req_blk_ext;
   logic [CmpW-1:0]               req_word;
   logic [CmpW-1:0]               held_word;
   logic [CmpW-1:0]               found_blk;
   logic                          accept;
   logic                          tail_valid;
   logic                          last_word;

   logic                          wr_en;
   logic [WIdxW-1:0]              wr_addr;
   bba_pkg::map_word_type         wr_data;
   logic                          rd_en;
   logic [WIdxW-1:0]              rd_addr;
   bba_pkg::map_word_type         rd_data;
   bba_pkg::scan_result_type      scan;

   bba_map_ram #(
      .DEPTH (MapWords),
      .AW    (WIdxW)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bba_word_scan u_scan (
      .used_word  (rd_data),
      .tail_valid (tail_valid),
      .tail_len   (remain[bba_pkg::BitIdxW-1:0]),
      .result     (scan)
   );

   always_comb begin
      total_ext   = LimW'(total_ff);
      limit       = (total_ext > LimW'(MAX_BLOCKS)) ? LimW'(MAX_BLOCKS) : total_ext;
      base        = CmpW'({ptr_ff, {bba_pkg::BitIdxW{1'b0}}});
      remain      = CmpW'(limit) - base;
      tail_valid  = remain < CmpW'(bba_pkg::WordBits);
      last_word   = remain <= CmpW'(bba_pkg::WordBits);
      req_blk_ext = CmpW'(req_block_number);
      req_word    = req_blk_ext >> bba_pkg::BitIdxW;
      held_word   = CmpW'(blk_ff) >> bba_pkg::BitIdxW;
      found_blk   = base | CmpW'(scan.bit_idx);
      accept      = start && (state_ff == ST_IDLE);
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      blk_in    = blk_ff;
      strobe_in = 1'b0;
      res_in    = res_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = ptr_ff;
      wr_data   = '0;
      rd_en     = 1'b0;
      rd_addr   = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (ptr_ff == WIdxW'(MapWords - 1)) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               blk_in = req_block_number;
               if (req_command == bba_pkg::CMD_ALLOC) begin
                  if (limit == '0) begin
                     strobe_in = 1'b1;
                     res_in    = '0;
                     status_in = bba_pkg::STATUS_FULL;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     ptr_in   = '0;
                     state_in = ST_SCAN;
                  end
               end else if (req_blk_ext >= CmpW'(limit)) begin
                  strobe_in = 1'b1;
                  res_in    = req_block_number;
                  status_in = bba_pkg::STATUS_RANGE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = req_word[WIdxW-1:0];
                  state_in = ST_FREE;
               end
            end
         end
         ST_SCAN: begin
            if (scan.found) begin
               wr_en     = 1'b1;
               wr_addr   = ptr_ff;
               wr_data   = rd_data | (bba_pkg::map_word_type'(1) << scan.bit_idx);
               count_in  = count_ff + 1'b1;
               strobe_in = 1'b1;
               res_in    = found_blk[bba_pkg::BlockW-1:0];
               status_in = bba_pkg::STATUS_OK;
               state_in  = ST_IDLE;
            end else if (last_word) begin
               strobe_in = 1'b1;
               res_in    = '0;
               status_in = bba_pkg::STATUS_FULL;
               state_in  = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff + 1'b1;
               ptr_in  = ptr_ff + 1'b1;
            end
         end
         ST_FREE: begin
            strobe_in = 1'b1;
            res_in    = blk_ff;
            state_in  = ST_IDLE;
            if (!rd_data[blk_ff[bba_pkg::BitIdxW-1:0]]) begin
               status_in = bba_pkg::STATUS_ALREADY_FREE;
            end else begin
               wr_en     = 1'b1;
               wr_addr   = held_word[WIdxW-1:0];
               wr_data   = rd_data &
                           ~(bba_pkg::map_word_type'(1) << blk_ff[bba_pkg::BitIdxW-1:0]);
               count_in  = count_ff - 1'b1;
               status_in = bba_pkg::STATUS_OK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         count_ff  <= '0;
         ptr_ff    <= '0;
         strobe_ff <= 1'b0;
         blk_ff    <= '0;
         res_ff    <= '0;
         status_ff <= '0;
         total_ff  <= bba_pkg::CountW'(4096);
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ptr_ff    <= ptr_in;
         strobe_ff <= strobe_in;
         blk_ff    <= blk_in;
         res_ff    <= res_in;
         status_ff <= status_in;
         if (csr_write_en) begin
            total_ff <= csr_write_data;
         end
      end
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_strobe           = strobe_ff;
   assign rsp_block_number_res = res_ff;
   assign rsp_status           = status_ff;
   assign rsp_used_count       = count_ff;

endmodule
`default_nettype wire
